>>> src/mqph_pkg.sv
// Package for the bounded multi-queue with urgent head insert.
// Holds the request and result beat types, the operation and result codes,
// and the command struct from the controller to the datapath. No dependencies.
package mqph_pkg;

  // Width of the identifier field on both channels.
  localparam int unsigned IdFieldW = 16;

  // Operation codes carried in a request beat.
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TAKE = 1'b1
  } op_e;

  // Result codes carried in a result beat.
  typedef enum logic [1:0] {
    RES_ADDED  = 2'd0,
    RES_FULL   = 2'd1,
    RES_SERVED = 2'd2,
    RES_EMPTY  = 2'd3
  } result_e;

  // One request beat.
  typedef struct packed {
    op_e                 opcode;
    logic [3:0]          queue_index;
    logic [IdFieldW-1:0] item_id;
    logic                urgent;
  } in_t;

  // One result beat.
  typedef struct packed {
    result_e             result_code;
    logic [IdFieldW-1:0] served_id;
    logic                served_urgent;
    logic [3:0]          queue_count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch the request and read the queue state
    logic exec;     // update queue state and entry storage
    logic deliver;  // move the finished result into the output register
  } cmd_t;

endpackage

>>> src/mqph_ctrl.sv
// Controller for the bounded multi-queue: sequences each request through
// state read, update and delivery, and owns the output valid flag.
// Depends on mqph_pkg for the command struct.
module mqph_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mqph_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_EXEC    = 3'b010,
    S_DELIVER = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Commands follow directly from the state and the input and output handshakes.
  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.load    = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.deliver = (state_q == S_DELIVER) && (!out_valid_q || out_ready_i);
  assign out_valid_o   = out_valid_q;

  // Next state: one request at a time, waiting in delivery while the output is busy.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DELIVER;
      end
      S_DELIVER: begin
        if (cmd_o.deliver) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output beat stays valid until it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.deliver) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // An accepted request is always followed by the update step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_EXEC))
    else $error("update step did not follow an accepted request");

  // The update step always hands over to delivery.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> (state_q == S_DELIVER))
    else $error("delivery did not follow the update step");

  // A delivered result shows up as a valid output beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.deliver |=> out_valid_o)
    else $error("delivered result is not presented");

  // A result waiting on a stalled output keeps the controller in delivery.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DELIVER) && out_valid_q && !out_ready_i) |=> (state_q == S_DELIVER))
    else $error("result dropped while the output was stalled");
`endif

endmodule

>>> src/mqph_dp.sv
// Datapath for the bounded multi-queue: per-queue head and count memory with
// valid flags, the entry memory, slot arithmetic and the output register.
// Depends on mqph_pkg for beat types, codes and the command struct.
module mqph_dp #(
  parameter int unsigned NUM_QUEUES  = 16,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mqph_pkg::cmd_t cmd_i,
  input  mqph_pkg::in_t  in_data_i,
  output mqph_pkg::out_t out_data_o
);

  localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW    = CW + 1;
  localparam int unsigned SW    = (ID_WIDTH < mqph_pkg::IdFieldW) ? ID_WIDTH
                                                                  : mqph_pkg::IdFieldW;
  localparam int unsigned SLOTS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic [HW-1:0] head;
    logic [CW-1:0] count;
  } qstate_t;

  typedef struct packed {
    logic          urgent;
    logic [SW-1:0] id;
  } entry_t;

  // Storage.
  qstate_t qstate_mem [NUM_QUEUES];
  entry_t  entry_mem  [SLOTS];
  logic [NUM_QUEUES-1:0] qvalid_q;

  // Request and read registers.
  mqph_pkg::in_t req_q;
  logic          in_range_q;
  logic          qvalid_rd_q;
  qstate_t       qstate_rd_q;
  entry_t        entry_rd_q;

  // Result held between the update step and delivery.
  mqph_pkg::result_e res_code_q, res_code_d;
  logic [3:0]        res_count_q, res_count_d;
  logic              res_served_q, res_served_d;
  mqph_pkg::out_t    out_q;

  logic          in_range;
  logic [QW-1:0] rd_sel;
  logic [QW-1:0] qsel;
  logic [HW-1:0] head;
  logic [CW-1:0] cnt;
  logic [PW-1:0] tail_sum;
  logic [HW-1:0] tail_pos;
  logic [HW-1:0] head_dec;
  logic [HW-1:0] head_inc;
  logic [HW-1:0] pos;
  logic [AW-1:0] slot;
  logic          qs_we;
  qstate_t       qs_wdata;
  logic          ent_we;
  logic          ent_re;

  // Request decode at acceptance: range check and queue state read address.
  assign in_range = 32'(in_data_i.queue_index) < 32'(NUM_QUEUES);
  assign rd_sel   = in_range ? QW'(in_data_i.queue_index) : '0;
  assign qsel     = in_range_q ? QW'(req_q.queue_index) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q       <= in_data_i;
      in_range_q  <= in_range;
      qvalid_rd_q <= qvalid_q[rd_sel];
      qstate_rd_q <= qstate_mem[rd_sel];
    end
  end

  // A queue never written since reset reads as empty with its head at slot zero.
  assign head = qvalid_rd_q ? qstate_rd_q.head  : '0;
  assign cnt  = qvalid_rd_q ? qstate_rd_q.count : '0;

  // Circular position arithmetic; the head stays below the depth and the count at most
  // reaches it, so one compare and subtract wraps the tail.
  assign tail_sum = PW'(head) + PW'(cnt);
  assign tail_pos = (tail_sum >= PW'(QUEUE_DEPTH)) ? HW'(tail_sum - PW'(QUEUE_DEPTH))
                                                   : HW'(tail_sum);
  assign head_dec = (head == '0) ? HW'(QUEUE_DEPTH - 1) : head - HW'(1);
  assign head_inc = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);
  assign slot     = AW'(AW'(qsel) * AW'(QUEUE_DEPTH)) + AW'(pos);

  // Update step: decide the outcome and the writes for the addressed queue.
  always_comb begin
    res_code_d   = mqph_pkg::RES_EMPTY;
    res_count_d  = '0;
    res_served_d = 1'b0;
    qs_we        = 1'b0;
    qs_wdata     = '{head: head, count: cnt};
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    pos          = head;
    if (!in_range_q) begin
      res_code_d = (req_q.opcode == mqph_pkg::OP_TAKE) ? mqph_pkg::RES_EMPTY
                                                       : mqph_pkg::RES_FULL;
    end else if (req_q.opcode == mqph_pkg::OP_ADD) begin
      if (cnt == CW'(QUEUE_DEPTH)) begin
        res_code_d  = mqph_pkg::RES_FULL;
        res_count_d = 4'(cnt);
      end else begin
        res_code_d     = mqph_pkg::RES_ADDED;
        res_count_d    = 4'(cnt + CW'(1));
        qs_we          = 1'b1;
        qs_wdata.count = cnt + CW'(1);
        ent_we         = 1'b1;
        if (req_q.urgent) begin
          qs_wdata.head = head_dec;
          pos           = head_dec;
        end else begin
          pos = tail_pos;
        end
      end
    end else begin
      if (cnt == '0) begin
        res_code_d = mqph_pkg::RES_EMPTY;
      end else begin
        res_code_d     = mqph_pkg::RES_SERVED;
        res_count_d    = 4'(cnt - CW'(1));
        res_served_d   = 1'b1;
        qs_we          = 1'b1;
        qs_wdata.head  = head_inc;
        qs_wdata.count = cnt - CW'(1);
        ent_re         = 1'b1;
      end
    end
  end

  // Queue state memory write.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && qs_we) begin
      qstate_mem[qsel] <= qs_wdata;
    end
  end

  // Per-queue valid flags mark queues whose state has been written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qvalid_q <= '0;
    end else if (cmd_i.exec && qs_we) begin
      qvalid_q[qsel] <= 1'b1;
    end
  end

  // Entry memory: one write or one registered read per update step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && ent_we) begin
      entry_mem[slot] <= '{urgent: req_q.urgent, id: SW'(req_q.item_id)};
    end
    if (cmd_i.exec && ent_re) begin
      entry_rd_q <= entry_mem[slot];
    end
  end

  // Hold the outcome until delivery.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_code_q   <= res_code_d;
      res_count_q  <= res_count_d;
      res_served_q <= res_served_d;
    end
  end

  // Output register; served fields read as zero unless an item was served.
  always_ff @(posedge clk_i) begin
    if (cmd_i.deliver) begin
      out_q.result_code   <= res_code_q;
      out_q.queue_count   <= res_count_q;
      out_q.served_id     <= res_served_q ? mqph_pkg::IdFieldW'(entry_rd_q.id) : '0;
      out_q.served_urgent <= res_served_q & entry_rd_q.urgent;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> src/multi_queue_priority_head_insert.sv
// A request passes the request and queue state read registers, the update step with its
// entry memory read and result registers, and the output register before its result is valid.
// A new request is taken only once the previous result has moved to the output register.
// Reset clears the controller, the output valid flag and the per-queue valid flags,
// so every queue starts empty at once; no clearing pass, entry storage is left as is.
// Top level: joins the controller (mqph_ctrl) and the datapath (mqph_dp).
module multi_queue_priority_head_insert #(
  parameter int unsigned NUM_QUEUES  = 16,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mqph_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mqph_pkg::out_t out_data_o
);

  mqph_pkg::cmd_t cmd;

  // Request sequencing and output handshake.
  mqph_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Queue storage and result formation.
  mqph_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
